>>> hdl/particle_force_euler_integrator_defines.svh
// ----------------------------------------------------------------------------
// Particle force Euler integrator: assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_FORCE_EULER_INTEGRATOR_DEFINES_SVH
`define PARTICLE_FORCE_EULER_INTEGRATOR_DEFINES_SVH

// same-cycle implication
`define PFEI_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFEI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pfei_pkg.sv
// ----------------------------------------------------------------------------
// Particle force Euler integrator: package
// Widths, codes, reset values and shared types for the integrator and its divider.
// ----------------------------------------------------------------------------
package pfei_pkg;

  localparam int DATA_W      = 32;
  localparam int Q_FRAC      = 16;
  localparam int FORCE_SLOTS = 16;
  localparam int SLOT_W      = (FORCE_SLOTS > 1) ? $clog2(FORCE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(FORCE_SLOTS + 1);
  localparam int SUM_W       = DATA_W + CNT_W;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int DIVD_W      = DATA_W + Q_FRAC;
  localparam int DIV_CNT_W   = $clog2(DIVD_W + 1);

  localparam int ACTION_W  = 3;
  localparam int INDEX_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(FORCE_SLOTS);

  localparam logic [DATA_W-1:0] MASS_RST    = 32'h0001_0000;
  localparam logic [DATA_W-1:0] DAMPING_RST = 32'h0000_0000;
  localparam logic [DATA_W-1:0] TSTEP_RST   = 32'd655;
  localparam logic              KINETIC_RST = 1'b1;

  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DIVD_W-1:0] Q_POS_LIM = DIVD_W'(S32_MAX);
  localparam logic [DIVD_W-1:0] Q_NEG_LIM = DIVD_W'(S32_MAX) + DIVD_W'(1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_STEP      = 3'd0,
    ACT_APPEND    = 3'd1,
    ACT_OVERWRITE = 3'd2,
    ACT_REMOVE    = 3'd3,
    ACT_LOAD_POS  = 3'd4,
    ACT_LOAD_VEL  = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_ZERO_MASS = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS      = 3'd0,
    CFG_DAMPING   = 3'd1,
    CFG_TIME_STEP = 3'd2,
    CFG_KINETIC   = 3'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SUM,
    S_NET,
    S_DIV_GO,
    S_DIV,
    S_ACC,
    S_MUL_V,
    S_VEL,
    S_MUL_P,
    S_POS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hdl/pfei_if.sv
// ----------------------------------------------------------------------------
// Particle force Euler integrator: channel interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface pfei_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [pfei_pkg::ACTION_W-1:0]  action;
  logic        [pfei_pkg::INDEX_W-1:0]   index;
  logic signed [pfei_pkg::DATA_W-1:0]    vec_x;
  logic signed [pfei_pkg::DATA_W-1:0]    vec_y;

  modport source (output valid, action, index, vec_x, vec_y, input ready);
  modport sink   (input valid, action, index, vec_x, vec_y, output ready);
endinterface

interface pfei_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pfei_pkg::DATA_W-1:0]    pos_x;
  logic signed [pfei_pkg::DATA_W-1:0]    pos_y;
  logic signed [pfei_pkg::DATA_W-1:0]    vel_x;
  logic signed [pfei_pkg::DATA_W-1:0]    vel_y;
  logic signed [pfei_pkg::DATA_W-1:0]    acc_x;
  logic signed [pfei_pkg::DATA_W-1:0]    acc_y;
  logic        [pfei_pkg::CNT_W-1:0]     force_count;
  logic        [pfei_pkg::STATUS_W-1:0]  status;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, force_count,
                  status, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, force_count,
                  status, output ready);
endinterface

interface pfei_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic        [pfei_pkg::CFG_IDX_W-1:0] index;
  logic        [pfei_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/pfei_div.sv
// ----------------------------------------------------------------------------
// Particle force Euler integrator: serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfei_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfei_pkg::div_req_t req_i,
  output pfei_pkg::div_rsp_t rsp_o
);

  logic                              busy_q, done_q;
  logic [pfei_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [pfei_pkg::DATA_W-1:0]       rem_q;
  logic [pfei_pkg::DIVD_W-1:0]       quo_q;
  logic [pfei_pkg::DATA_W-1:0]       dvs_q;

  logic [pfei_pkg::DATA_W:0]         rem_sh;
  logic [pfei_pkg::DATA_W+1:0]       diff;
  logic                              ge;

  assign rem_sh = {rem_q, quo_q[pfei_pkg::DIVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[pfei_pkg::DATA_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == pfei_pkg::DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= pfei_pkg::DIV_CNT_W'(pfei_pkg::DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - pfei_pkg::DIV_CNT_W'(1);
        if (cnt_q == pfei_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // remainder stays below the divisor, so the low word is enough
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[pfei_pkg::DATA_W-1:0] : rem_sh[pfei_pkg::DATA_W-1:0];
      quo_q <= {quo_q[pfei_pkg::DIVD_W-2:0], ge};
    end
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quotient: quo_q};

endmodule

>>> hdl/particle_force_euler_integrator.sv
// ----------------------------------------------------------------------------
// Particle force Euler integrator
// One 2D particle, a force table in RAM and a sequenced semi-implicit Euler step.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries a command word (action, index, vec_x, vec_y); every accepted
//   word yields exactly one result word on res_o with the particle state after
//   the command, the force count and a status code.
//   cfg_i writes mass, damping, time step and the kinetic flag; write only
//   while no command is in flight.
//   One command at a time. Table edits and loads pass from an execute state to
//   a done state; a remove shifts every later entry down through the RAM port
//   between them, with a read and a write state per entry. A step sums one RAM
//   read per force, then runs a 48-bit serial division by mass (x and y in
//   parallel) and the multiply and update states for velocity and position,
//   which a static particle skips. Zero mass ends a step with no arithmetic.
//   A new command is taken while the previous result still waits in the
//   output register; a stalled receiver holds the block before its result.
//   Reset clears position, velocity, acceleration and the force count and
//   loads the register defaults; the table RAM is not cleared.
// ----------------------------------------------------------------------------
`include "particle_force_euler_integrator_defines.svh"

module particle_force_euler_integrator (
  input  logic            clk_i,
  input  logic            rst_ni,
  pfei_in_if.sink         in_i,
  pfei_cfg_if.sink        cfg_i,
  pfei_res_if.source      res_o
);

  localparam int DW = pfei_pkg::DATA_W;
  localparam int PW = pfei_pkg::PROD_W;
  localparam int QF = pfei_pkg::Q_FRAC;

  pfei_pkg::state_e  state_q, state_d;
  pfei_pkg::status_e status_q, status_d;
  pfei_pkg::action_e act_q;

  logic [pfei_pkg::CNT_W-1:0]   used_q, used_d;
  logic [pfei_pkg::CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic [pfei_pkg::CNT_W-1:0]   rd_prev;
  logic                         rvld_q, rvld_d;
  logic [pfei_pkg::INDEX_W-1:0] idx_q;
  logic signed [DW-1:0]         vx_q, vy_q;

  logic [DW-1:0] mass_q, damp_q, ts_q;
  logic          kin_q;

  logic signed [DW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [DW-1:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic signed [DW-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;

  logic signed [pfei_pkg::SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic signed [DW-1:0]              nsat_x_q, nsat_x_d, nsat_y_q, nsat_y_d;

  // shared multiplier pair
  logic                 mul_en;
  logic signed [DW-1:0] mul_a_x, mul_a_y;
  logic [DW-1:0]        mul_b;
  logic signed [PW+1:0] mul_full_x, mul_full_y;
  logic signed [PW-1:0] prod_x_q, prod_y_q;
  logic signed [PW-QF-1:0] fl_x, fl_y;
  logic signed [PW-1:0] net_x, net_y;

  // force table RAM, word = {y, x}
  logic [2*DW-1:0]              ftab_mem [pfei_pkg::FORCE_SLOTS];
  logic                         mem_we;
  logic [pfei_pkg::SLOT_W-1:0]  mem_waddr, mem_raddr;
  logic [2*DW-1:0]              mem_wdata, mem_rdata_q;
  logic signed [DW-1:0]         rd_x, rd_y;

  pfei_pkg::div_req_t div_req_x, div_req_y;
  pfei_pkg::div_rsp_t div_rsp_x, div_rsp_y;
  logic               div_go;
  logic [DW-1:0]      mag_x, mag_y;

  logic out_valid_q, out_valid_d, out_load;
  logic idx_bad;
  logic signed [DW-1:0] out_pos_x_q, out_pos_y_q, out_vel_x_q, out_vel_y_q;
  logic signed [DW-1:0] out_acc_x_q, out_acc_y_q;
  logic [pfei_pkg::CNT_W-1:0] out_cnt_q;
  pfei_pkg::status_e          out_status_q;

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > PW'(pfei_pkg::S32_MAX)) begin
      r = pfei_pkg::S32_MAX;
    end else if (v < PW'(pfei_pkg::S32_MIN)) begin
      r = pfei_pkg::S32_MIN;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // quotient magnitude back to signed, truncated toward zero
  function automatic logic signed [DW-1:0] qsat(input logic neg,
                                                input logic [pfei_pkg::DIVD_W-1:0] q);
    logic signed [DW-1:0] r;
    if (neg) begin
      r = (q > pfei_pkg::Q_NEG_LIM) ? pfei_pkg::S32_MIN : -q[DW-1:0];
    end else begin
      r = (q > pfei_pkg::Q_POS_LIM) ? pfei_pkg::S32_MAX : q[DW-1:0];
    end
    return r;
  endfunction

  assign in_i.ready  = (state_q == pfei_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign idx_bad = (32'(idx_q) >= 32'(used_q)) || (32'(idx_q) >= pfei_pkg::FORCE_SLOTS);
  assign rd_prev = rd_cnt_q - pfei_pkg::CNT_W'(1);
  assign rd_x    = mem_rdata_q[DW-1:0];
  assign rd_y    = mem_rdata_q[2*DW-1:DW];

  assign mul_full_x = $signed({mul_a_x[DW-1], mul_a_x}) * $signed({1'b0, mul_b});
  assign mul_full_y = $signed({mul_a_y[DW-1], mul_a_y}) * $signed({1'b0, mul_b});
  // arithmetic shift right gives the floor
  assign fl_x  = prod_x_q[PW-1:QF];
  assign fl_y  = prod_y_q[PW-1:QF];
  assign net_x = PW'(sum_x_q) - PW'(fl_x);
  assign net_y = PW'(sum_y_q) - PW'(fl_y);

  assign mag_x = nsat_x_q[DW-1] ? (~nsat_x_q + DW'(1)) : nsat_x_q;
  assign mag_y = nsat_y_q[DW-1] ? (~nsat_y_q + DW'(1)) : nsat_y_q;
  assign div_req_x = '{start: div_go, dividend: {mag_x, {QF{1'b0}}}, divisor: mass_q};
  assign div_req_y = '{start: div_go, dividend: {mag_y, {QF{1'b0}}}, divisor: mass_q};

  pfei_div u_div_x (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req_x),
    .rsp_o (div_rsp_x)
  );

  pfei_div u_div_y (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req_y),
    .rsp_o (div_rsp_y)
  );

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    used_d      = used_q;
    rd_cnt_d    = rd_cnt_q;
    rvld_d      = 1'b0;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    vel_x_d     = vel_x_q;
    vel_y_d     = vel_y_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    nsat_x_d    = nsat_x_q;
    nsat_y_d    = nsat_y_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = used_q[pfei_pkg::SLOT_W-1:0];
    mem_wdata   = {vy_q, vx_q};
    mem_raddr   = rd_cnt_q[pfei_pkg::SLOT_W-1:0];
    mul_en      = 1'b0;
    mul_a_x     = vel_x_q;
    mul_a_y     = vel_y_q;
    mul_b       = ts_q;
    div_go      = 1'b0;

    unique case (state_q)
      pfei_pkg::S_IDLE: begin
        if (in_i.valid) begin
          state_d = pfei_pkg::S_EXEC;
        end
      end
      pfei_pkg::S_EXEC: begin
        status_d = pfei_pkg::ST_OK;
        state_d  = pfei_pkg::S_DONE;
        unique case (act_q)
          pfei_pkg::ACT_STEP: begin
            if (mass_q == '0) begin
              status_d = pfei_pkg::ST_ZERO_MASS;
            end else begin
              // damping product runs alongside the force sum
              mul_en   = 1'b1;
              mul_b    = damp_q;
              rd_cnt_d = '0;
              sum_x_d  = '0;
              sum_y_d  = '0;
              state_d  = pfei_pkg::S_SUM;
            end
          end
          pfei_pkg::ACT_APPEND: begin
            if (used_q >= pfei_pkg::SLOTS_CNT) begin
              status_d = pfei_pkg::ST_BAD_INDEX;
            end else begin
              mem_we = 1'b1;
              used_d = used_q + pfei_pkg::CNT_W'(1);
            end
          end
          pfei_pkg::ACT_OVERWRITE: begin
            if (idx_bad) begin
              status_d = pfei_pkg::ST_BAD_INDEX;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = pfei_pkg::SLOT_W'(idx_q);
            end
          end
          pfei_pkg::ACT_REMOVE: begin
            if (idx_bad) begin
              status_d = pfei_pkg::ST_BAD_INDEX;
            end else begin
              rd_cnt_d = pfei_pkg::CNT_W'(idx_q) + pfei_pkg::CNT_W'(1);
              state_d  = pfei_pkg::S_SHIFT_RD;
            end
          end
          pfei_pkg::ACT_LOAD_POS: begin
            pos_x_d = vx_q;
            pos_y_d = vy_q;
          end
          pfei_pkg::ACT_LOAD_VEL: begin
            vel_x_d = vx_q;
            vel_y_d = vy_q;
          end
          default: ;
        endcase
      end
      pfei_pkg::S_SUM: begin
        if (rd_cnt_q < used_q) begin
          rd_cnt_d = rd_cnt_q + pfei_pkg::CNT_W'(1);
          rvld_d   = 1'b1;
        end
        if (rvld_q) begin
          sum_x_d = sum_x_q + pfei_pkg::SUM_W'(rd_x);
          sum_y_d = sum_y_q + pfei_pkg::SUM_W'(rd_y);
        end
        if ((rd_cnt_q >= used_q) && !rvld_q) begin
          state_d = pfei_pkg::S_NET;
        end
      end
      pfei_pkg::S_NET: begin
        nsat_x_d = sat32(net_x);
        nsat_y_d = sat32(net_y);
        state_d  = pfei_pkg::S_DIV_GO;
      end
      pfei_pkg::S_DIV_GO: begin
        div_go  = 1'b1;
        state_d = pfei_pkg::S_DIV;
      end
      pfei_pkg::S_DIV: begin
        if (div_rsp_x.done) begin
          state_d = pfei_pkg::S_ACC;
        end
      end
      pfei_pkg::S_ACC: begin
        acc_x_d = qsat(nsat_x_q[DW-1], div_rsp_x.quotient);
        acc_y_d = qsat(nsat_y_q[DW-1], div_rsp_y.quotient);
        if (kin_q) begin
          state_d = pfei_pkg::S_MUL_V;
        end else begin
          vel_x_d = '0;
          vel_y_d = '0;
          state_d = pfei_pkg::S_DONE;
        end
      end
      pfei_pkg::S_MUL_V: begin
        mul_en  = 1'b1;
        mul_a_x = acc_x_q;
        mul_a_y = acc_y_q;
        state_d = pfei_pkg::S_VEL;
      end
      pfei_pkg::S_VEL: begin
        vel_x_d = sat32(PW'(vel_x_q) + PW'(fl_x));
        vel_y_d = sat32(PW'(vel_y_q) + PW'(fl_y));
        state_d = pfei_pkg::S_MUL_P;
      end
      pfei_pkg::S_MUL_P: begin
        mul_en  = 1'b1;
        state_d = pfei_pkg::S_POS;
      end
      pfei_pkg::S_POS: begin
        pos_x_d = sat32(PW'(pos_x_q) + PW'(fl_x));
        pos_y_d = sat32(PW'(pos_y_q) + PW'(fl_y));
        state_d = pfei_pkg::S_DONE;
      end
      pfei_pkg::S_SHIFT_RD: begin
        if (rd_cnt_q < used_q) begin
          state_d = pfei_pkg::S_SHIFT_WR;
        end else begin
          used_d  = used_q - pfei_pkg::CNT_W'(1);
          state_d = pfei_pkg::S_DONE;
        end
      end
      pfei_pkg::S_SHIFT_WR: begin
        // entry k+1 moves down to k
        mem_we    = 1'b1;
        mem_waddr = rd_prev[pfei_pkg::SLOT_W-1:0];
        mem_wdata = mem_rdata_q;
        rd_cnt_d  = rd_cnt_q + pfei_pkg::CNT_W'(1);
        state_d   = pfei_pkg::S_SHIFT_RD;
      end
      pfei_pkg::S_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = pfei_pkg::S_IDLE;
        end
      end
      default: state_d = pfei_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfei_pkg::S_IDLE;
      status_q    <= pfei_pkg::ST_OK;
      used_q      <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      mass_q      <= pfei_pkg::MASS_RST;
      damp_q      <= pfei_pkg::DAMPING_RST;
      ts_q        <= pfei_pkg::TSTEP_RST;
      kin_q       <= pfei_pkg::KINETIC_RST;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      used_q      <= used_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      vel_x_q     <= vel_x_d;
      vel_y_q     <= vel_y_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (pfei_pkg::cfg_idx_e'(cfg_i.index))
          pfei_pkg::CFG_MASS:      mass_q <= cfg_i.data;
          pfei_pkg::CFG_DAMPING:   damp_q <= cfg_i.data;
          pfei_pkg::CFG_TIME_STEP: ts_q   <= cfg_i.data;
          pfei_pkg::CFG_KINETIC:   kin_q  <= cfg_i.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q <= pfei_pkg::action_e'(in_i.action);
      idx_q <= in_i.index;
      vx_q  <= in_i.vec_x;
      vy_q  <= in_i.vec_y;
    end
    rd_cnt_q <= rd_cnt_d;
    sum_x_q  <= sum_x_d;
    sum_y_q  <= sum_y_d;
    nsat_x_q <= nsat_x_d;
    nsat_y_q <= nsat_y_d;
    if (mul_en) begin
      prod_x_q <= mul_full_x[PW-1:0];
      prod_y_q <= mul_full_y[PW-1:0];
    end
    if (out_load) begin
      out_pos_x_q  <= pos_x_q;
      out_pos_y_q  <= pos_y_q;
      out_vel_x_q  <= vel_x_q;
      out_vel_y_q  <= vel_y_q;
      out_acc_x_q  <= acc_x_q;
      out_acc_y_q  <= acc_y_q;
      out_cnt_q    <= used_q;
      out_status_q <= status_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ftab_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= ftab_mem[mem_raddr];
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.pos_x       = out_pos_x_q;
  assign res_o.pos_y       = out_pos_y_q;
  assign res_o.vel_x       = out_vel_x_q;
  assign res_o.vel_y       = out_vel_y_q;
  assign res_o.acc_x       = out_acc_x_q;
  assign res_o.acc_y       = out_acc_y_q;
  assign res_o.force_count = out_cnt_q;
  assign res_o.status      = out_status_q;

  `PFEI_ASSERT(a_used_bound, 1'b1, used_q <= pfei_pkg::SLOTS_CNT, "force count above table size")
  `PFEI_ASSERT(a_mem_we_state, mem_we, state_q == pfei_pkg::S_EXEC || state_q == pfei_pkg::S_SHIFT_WR, "table write outside edit states")
  `PFEI_ASSERT(a_div_done_state, div_rsp_x.done, state_q == pfei_pkg::S_DIV, "divider finished outside wait state")
  `PFEI_ASSERT(a_div_lockstep, 1'b1, div_rsp_x.done == div_rsp_y.done, "x and y dividers out of step")
  `PFEI_ASSERT_NXT(a_accept_exec, in_i.valid && in_i.ready, state_q == pfei_pkg::S_EXEC, "accepted word not executed")

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Particle force Euler integrator: testbench
// Sends command words and register writes with random gaps and stalls. Every
// result word is checked against a cycle-free model of the particle, its force
// table and the Q16.16 step arithmetic.
// ----------------------------------------------------------------------------
module tb;
  import pfei_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam int                  GAP_MAX     = 12;
  localparam int                  MAX_SHOWN   = 10;
  localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh0000_8000;

  typedef struct {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] acc_x;
    logic signed [DATA_W-1:0] acc_y;
    logic [CNT_W-1:0]         force_count;
    logic [STATUS_W-1:0]      status;
  } particle_view_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pfei_in_if  in_if ();
  pfei_res_if res_if ();
  pfei_cfg_if cfg_if ();

  particle_force_euler_integrator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // particle model state
  logic [DATA_W-1:0]        mass_q, damping_q, tstep_q;
  logic                     kinetic_q;
  logic signed [DATA_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q, acc_x_q, acc_y_q;
  logic signed [DATA_W-1:0] force_x_q [FORCE_SLOTS];
  logic signed [DATA_W-1:0] force_y_q [FORCE_SLOTS];
  int unsigned              forces_held;

  particle_view_t pending_views [$];

  bit no_idle;
  int hold_left;
  int mismatches, results_seen, words_sent, steps_sent, rejects_seen, zero_mass_seen;
  int reg_writes;

  function automatic void reset_model();
    mass_q      = MASS_RST;
    damping_q   = DAMPING_RST;
    tstep_q     = TSTEP_RST;
    kinetic_q   = KINETIC_RST;
    pos_x_q     = '0;
    pos_y_q     = '0;
    vel_x_q     = '0;
    vel_y_q     = '0;
    acc_x_q     = '0;
    acc_y_q     = '0;
    forces_held = 0;
    for (int k = 0; k < FORCE_SLOTS; k++) begin
      force_x_q[k] = '0;
      force_y_q[k] = '0;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_s32(input longint v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return v[DATA_W-1:0];
  endfunction

  // signed Q16.16 times unsigned Q16.16, floored back to Q16.16
  function automatic longint scale_q16(input logic signed [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
    return (longint'(a) * longint'({32'd0, b})) >>> Q_FRAC;
  endfunction

  function automatic logic [STATUS_W-1:0] integrate_step();
    longint                   fx, fy, m;
    logic signed [DATA_W-1:0] nx, ny;
    if (mass_q == '0) return ST_ZERO_MASS;
    fx = 0;
    fy = 0;
    for (int k = 0; k < int'(forces_held); k++) begin
      fx += longint'(force_x_q[k]);
      fy += longint'(force_y_q[k]);
    end
    fx -= scale_q16(vel_x_q, damping_q);
    fy -= scale_q16(vel_y_q, damping_q);
    nx = clamp_s32(fx);
    ny = clamp_s32(fy);
    m  = longint'({32'd0, mass_q});
    // division truncates toward zero
    acc_x_q = clamp_s32((longint'(nx) * 65536) / m);
    acc_y_q = clamp_s32((longint'(ny) * 65536) / m);
    if (kinetic_q) begin
      vel_x_q = clamp_s32(longint'(vel_x_q) + scale_q16(acc_x_q, tstep_q));
      vel_y_q = clamp_s32(longint'(vel_y_q) + scale_q16(acc_y_q, tstep_q));
      pos_x_q = clamp_s32(longint'(pos_x_q) + scale_q16(vel_x_q, tstep_q));
      pos_y_q = clamp_s32(longint'(pos_y_q) + scale_q16(vel_y_q, tstep_q));
    end else begin
      vel_x_q = '0;
      vel_y_q = '0;
    end
    return ST_OK;
  endfunction

  function automatic void apply_command(input logic [ACTION_W-1:0] act,
                                        input logic [INDEX_W-1:0] idx,
                                        input logic signed [DATA_W-1:0] vx, vy);
    particle_view_t      view;
    logic [STATUS_W-1:0] st;
    st = ST_OK;
    case (act)
      ACT_STEP: begin
        st = integrate_step();
        steps_sent++;
      end
      ACT_APPEND: begin
        if (forces_held >= FORCE_SLOTS) begin
          st = ST_BAD_INDEX;
        end else begin
          force_x_q[forces_held] = vx;
          force_y_q[forces_held] = vy;
          forces_held++;
        end
      end
      ACT_OVERWRITE: begin
        if (int'(idx) >= int'(forces_held)) begin
          st = ST_BAD_INDEX;
        end else begin
          force_x_q[idx] = vx;
          force_y_q[idx] = vy;
        end
      end
      ACT_REMOVE: begin
        if (int'(idx) >= int'(forces_held)) begin
          st = ST_BAD_INDEX;
        end else begin
          for (int k = int'(idx); k + 1 < int'(forces_held); k++) begin
            force_x_q[k] = force_x_q[k+1];
            force_y_q[k] = force_y_q[k+1];
          end
          forces_held--;
        end
      end
      ACT_LOAD_POS: begin
        pos_x_q = vx;
        pos_y_q = vy;
      end
      ACT_LOAD_VEL: begin
        vel_x_q = vx;
        vel_y_q = vy;
      end
      default: ;
    endcase
    if (st == ST_BAD_INDEX) rejects_seen++;
    if (st == ST_ZERO_MASS) zero_mass_seen++;
    view.pos_x       = pos_x_q;
    view.pos_y       = pos_y_q;
    view.vel_x       = vel_x_q;
    view.vel_y       = vel_y_q;
    view.acc_x       = acc_x_q;
    view.acc_y       = acc_y_q;
    view.force_count = CNT_W'(forces_held);
    view.status      = st;
    pending_views.push_back(view);
  endfunction

  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_q16();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      4, 5, 6:    return $urandom;
      7:          return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      8: begin
        case ($urandom_range(0, 3))
          0:       return S32_MAX;
          1:       return S32_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:    return $urandom_range(0, 32'h0000_FFFF);
    endcase
  endfunction

  function automatic void check_view();
    particle_view_t want;
    bit             bad;
    results_seen++;
    if (pending_views.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("result word with nothing expected at %0t", $time);
      return;
    end
    want = pending_views.pop_front();
    bad = (res_if.pos_x !== want.pos_x) || (res_if.pos_y !== want.pos_y) ||
          (res_if.vel_x !== want.vel_x) || (res_if.vel_y !== want.vel_y) ||
          (res_if.acc_x !== want.acc_x) || (res_if.acc_y !== want.acc_y) ||
          (res_if.force_count !== want.force_count) || (res_if.status !== want.status);
    if (bad) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("mismatch at %0t", $time);
        $display("  exp pos %h %h vel %h %h acc %h %h count %0d status %0d",
                 want.pos_x, want.pos_y, want.vel_x, want.vel_y, want.acc_x, want.acc_y,
                 want.force_count, want.status);
        $display("  got pos %h %h vel %h %h acc %h %h count %0d status %0d",
                 res_if.pos_x, res_if.pos_y, res_if.vel_x, res_if.vel_y, res_if.acc_x,
                 res_if.acc_y, res_if.force_count, res_if.status);
      end
    end
  endfunction

  // result side: per-word stall, plus a long hold-off when a test asks for one
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        check_view();
        stall_left = draw_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] vx, vy);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.index  <= idx;
    in_if.vec_x  <= vx;
    in_if.vec_y  <= vy;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    apply_command(act, idx, vx, vy);
    words_sent++;
  endtask

  task automatic send_random_word();
    int                  pick;
    logic [ACTION_W-1:0] act;
    logic [INDEX_W-1:0]  idx;
    pick = $urandom_range(0, 99);
    if (pick < 25)      act = ACT_STEP;
    else if (pick < 45) act = ACT_APPEND;
    else if (pick < 60) act = ACT_OVERWRITE;
    else if (pick < 72) act = ACT_REMOVE;
    else if (pick < 82) act = ACT_LOAD_POS;
    else if (pick < 94) act = ACT_LOAD_VEL;
    else if (pick < 97) act = ACT_SPARE_6;
    else                act = ACT_SPARE_7;
    // mostly a slot in use, sometimes anywhere
    if (forces_held > 0 && $urandom_range(0, 3) != 0)
      idx = INDEX_W'($urandom_range(0, forces_held - 1));
    else
      idx = INDEX_W'($urandom);
    send_word(act, idx, draw_q16(), draw_q16());
  endtask

  task automatic send_random_words(input int count);
    repeat (count) send_random_word();
  endtask

  // stop offering and wait for every outstanding result word
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DATA_W-1:0] value);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_MASS:      mass_q    = value;
      CFG_DAMPING:   damping_q = value;
      CFG_TIME_STEP: tstep_q   = value;
      CFG_KINETIC:   kinetic_q = value[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic write_settings(input logic [DATA_W-1:0] mass, damping, tstep, kin);
    write_reg(CFG_MASS, mass);
    write_reg(CFG_DAMPING, damping);
    write_reg(CFG_TIME_STEP, tstep);
    write_reg(CFG_KINETIC, kin);
  endtask

  task automatic test_directed();
    send_word(ACT_STEP, '0, '0, '0);
    send_word(ACT_LOAD_POS, '0, S32_MAX, S32_MIN);
    send_word(ACT_LOAD_VEL, 4'hF, S32_MIN, S32_MAX);
    send_word(ACT_APPEND, '0, S32_MAX, S32_MIN);
    send_word(ACT_APPEND, 4'hF, S32_MAX, S32_MIN);
    send_word(ACT_APPEND, '0, Q_ONE, -Q_ONE);
    send_word(ACT_OVERWRITE, 4'd2, -2 * Q_ONE, Q_HALF);
    send_word(ACT_OVERWRITE, 4'hF, Q_ONE, Q_ONE);
    send_word(ACT_REMOVE, 4'd3, '0, '0);
    // net force saturates and the acceleration lands on the same limits
    send_word(ACT_STEP, '0, '0, '0);
    send_word(ACT_STEP, 4'hA, S32_MIN, S32_MAX);
    send_word(ACT_REMOVE, 4'd0, '0, '0);
    send_word(ACT_REMOVE, 4'd1, '0, '0);
    send_word(ACT_OVERWRITE, 4'd0, S32_MIN, S32_MAX);
    send_word(ACT_SPARE_6, 4'hF, S32_MIN, S32_MAX);
    send_word(ACT_SPARE_7, 4'h5, S32_MAX, S32_MIN);
    send_word(ACT_LOAD_VEL, '0, Q_HALF, -Q_HALF);
    send_word(ACT_LOAD_POS, '0, '0, '0);
    send_word(ACT_STEP, '0, '0, '0);
    send_word(ACT_REMOVE, 4'd0, '0, '0);
    send_word(ACT_REMOVE, 4'd0, '0, '0);
    send_word(ACT_OVERWRITE, 4'd0, Q_ONE, Q_ONE);
    send_word(ACT_STEP, '0, '0, '0);
  endtask

  task automatic test_table_full();
    while (forces_held < FORCE_SLOTS) send_word(ACT_APPEND, INDEX_W'($urandom),
                                                draw_q16(), draw_q16());
    send_word(ACT_APPEND, '0, Q_ONE, Q_ONE);
    send_word(ACT_OVERWRITE, 4'hF, S32_MIN, S32_MIN);
    send_word(ACT_STEP, '0, '0, '0);
    // longest shift-down, then refill and drop the top slot
    send_word(ACT_REMOVE, 4'd0, '0, '0);
    send_word(ACT_APPEND, '0, -Q_ONE, Q_ONE);
    send_word(ACT_REMOVE, 4'hF, '0, '0);
    send_word(ACT_STEP, '0, '0, '0);
  endtask

  task automatic test_corner_settings();
    write_reg(CFG_MASS, '0);
    send_word(ACT_LOAD_VEL, '0, Q_ONE, -Q_ONE);
    send_word(ACT_STEP, '0, '0, '0);
    send_random_words(20);
    // static particle: acceleration still updates, velocity cleared
    write_settings(MASS_RST, 32'h0000_4000, TSTEP_RST, 32'h0);
    send_word(ACT_LOAD_VEL, '0, S32_MAX, S32_MIN);
    send_word(ACT_STEP, '0, '0, '0);
    send_random_words(20);
    write_settings(32'd1, '1, '1, 32'd1);
    send_random_words(30);
    write_settings('1, '0, '0, 32'hFFFF_FFFE);
    send_random_words(30);
    write_settings(MASS_RST, 32'h0000_2000, TSTEP_RST, '1);
    send_random_words(30);
  endtask

  task automatic test_input_stall();
    no_idle   = 1'b1;
    hold_left = 300;
    send_random_words(24);
    no_idle = 1'b0;
    settle();
  endtask

  task automatic test_random_phases();
    logic [DATA_W-1:0] mass;
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 9))
        0:       mass = '0;
        1:       mass = 32'd1;
        2:       mass = '1;
        default: mass = $urandom_range(32'h0000_1000, 32'h0010_0000);
      endcase
      write_settings(mass, $urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0001_0000),
                     $urandom);
      for (int n = 0; n < 200; n++) begin
        no_idle = (n % 100) >= 70;
        send_random_word();
      end
      no_idle = 1'b0;
    end
  endtask

  task automatic finish_run();
    int waited;
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_views.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    mismatches += pending_views.size();
    $display("Sent %0d command words (%0d steps, %0d rejected edits, %0d zero-mass steps)",
             words_sent, steps_sent, rejects_seen, zero_mass_seen);
    $display("over %0d register writes; %0d result words checked, %0d failures",
             reg_writes, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.action = ACT_STEP;
    in_if.index  = '0;
    in_if.vec_x  = '0;
    in_if.vec_y  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_MASS;
    cfg_if.data  = '0;
    no_idle      = 1'b0;
    hold_left    = 0;
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_corner_settings();
    test_input_stall();
    test_random_phases();
    finish_run();
  end

  initial begin
    #10_000_000;
    $display("run timed out with %0d result words outstanding", pending_views.size());
    $display("FAIL");
    $finish;
  end

endmodule
